// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Package for the text console writer: request/result structs, character and
// register codes, and the microcode ROM that sequences the datapath.
// No dependencies.
package tcw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ROWX_W = ROW_W + 1;
    localparam int COLX_W = COL_W + 1;
    localparam int MAC_W  = ROW_W + COL_W + 1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       char_in;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_col;
    } req_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [7:0]       cell_color;
        logic [ROW_W-1:0] cursor_row_out;
        logic [COL_W-1:0] cursor_col_out;
        logic             scrolled;
    } res_t;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [7:0] TEXT_COLOR_RST   = 8'h03;
    localparam logic [7:0] CURSOR_COLOR_RST = 8'h80;
    localparam logic [6:0] COLS_RST         = 7'd80;
    localparam logic [4:0] ROWS_RST         = 5'd25;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_TEXT_COLOR   = 2'd0;
    localparam logic [1:0] REG_CURSOR_COLOR = 2'd1;
    localparam logic [1:0] REG_COLUMNS      = 2'd2;
    localparam logic [1:0] REG_ROWS         = 2'd3;

    // microcode steps
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISP      = 4'd1;
    localparam logic [3:0] S_CUR_ADDR  = 4'd2;
    localparam logic [3:0] S_CUR_RD    = 4'd3;
    localparam logic [3:0] S_CUR_WR    = 4'd4;
    localparam logic [3:0] S_SCR_INIT  = 4'd5;
    localparam logic [3:0] S_COPY      = 4'd6;
    localparam logic [3:0] S_FILL      = 4'd7;
    localparam logic [3:0] S_SHOW_ADDR = 4'd8;
    localparam logic [3:0] S_SHOW_RD   = 4'd9;
    localparam logic [3:0] S_SHOW_WR   = 4'd10;
    localparam logic [3:0] S_RD_ADDR   = 4'd11;
    localparam logic [3:0] S_RD_RD     = 4'd12;
    localparam logic [3:0] S_RD_CAP    = 4'd13;
    localparam logic [3:0] S_FIN       = 4'd14;
    localparam logic [3:0] S_CLR       = 4'd15;

    // datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_CLR_RES  = 4'd1;
    localparam logic [3:0] OP_ADDR_CUR = 4'd2;
    localparam logic [3:0] OP_PUT      = 4'd3;
    localparam logic [3:0] OP_SCR_INIT = 4'd4;
    localparam logic [3:0] OP_COPY     = 4'd5;
    localparam logic [3:0] OP_FILL     = 4'd6;
    localparam logic [3:0] OP_SHOW     = 4'd7;
    localparam logic [3:0] OP_ADDR_RD  = 4'd8;
    localparam logic [3:0] OP_CAP      = 4'd9;
    localparam logic [3:0] OP_EMIT     = 4'd10;
    localparam logic [3:0] OP_CLEAR    = 4'd11;

    // sequencing: next step, jump if cond else next, jump if cond else hold
    localparam logic [1:0] SEQ_NEXT = 2'd0;
    localparam logic [1:0] SEQ_JUMP = 2'd1;
    localparam logic [1:0] SEQ_WAIT = 2'd2;

    localparam logic [3:0] C_ALWAYS    = 4'd0;
    localparam logic [3:0] C_REQ       = 4'd1;
    localparam logic [3:0] C_READ      = 4'd2;
    localparam logic [3:0] C_ZERO      = 4'd3;
    localparam logic [3:0] C_NO_SCROLL = 4'd4;
    localparam logic [3:0] C_COPY_END  = 4'd5;
    localparam logic [3:0] C_FILL_END  = 4'd6;
    localparam logic [3:0] C_OUT_FREE  = 4'd7;
    localparam logic [3:0] C_CLR_END   = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] seq;
        logic [3:0] cond;
        logic [3:0] target;
    } uword_t;

    function automatic uword_t ucode(input logic [3:0] step);
        uword_t w;
        case (step)
            S_IDLE:      w = '{OP_NOP,      SEQ_WAIT, C_REQ,       S_DISP};
            S_DISP:      w = '{OP_CLR_RES,  SEQ_JUMP, C_READ,      S_RD_ADDR};
            S_CUR_ADDR:  w = '{OP_ADDR_CUR, SEQ_JUMP, C_ZERO,      S_FIN};
            S_CUR_RD:    w = '{OP_NOP,      SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_CUR_WR:    w = '{OP_PUT,      SEQ_JUMP, C_NO_SCROLL, S_SHOW_ADDR};
            S_SCR_INIT:  w = '{OP_SCR_INIT, SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_COPY:      w = '{OP_COPY,     SEQ_WAIT, C_COPY_END,  S_FILL};
            S_FILL:      w = '{OP_FILL,     SEQ_WAIT, C_FILL_END,  S_SHOW_ADDR};
            S_SHOW_ADDR: w = '{OP_ADDR_CUR, SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_SHOW_RD:   w = '{OP_NOP,      SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_SHOW_WR:   w = '{OP_SHOW,     SEQ_JUMP, C_ALWAYS,    S_FIN};
            S_RD_ADDR:   w = '{OP_ADDR_RD,  SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_RD_RD:     w = '{OP_NOP,      SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_RD_CAP:    w = '{OP_CAP,      SEQ_NEXT, C_ALWAYS,    S_IDLE};
            S_FIN:       w = '{OP_EMIT,     SEQ_WAIT, C_OUT_FREE,  S_IDLE};
            S_CLR:       w = '{OP_CLEAR,    SEQ_WAIT, C_CLR_END,   S_IDLE};
            default:     w = '{OP_NOP,      SEQ_JUMP, C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/text_console_writer.sv
`timescale 1ns / 1ps
// Text console writer top level: screen store, cursor and the microcoded
// sequencer that runs puts, scrolls and cell reads. Depends on tcw_pkg.
//
// Usage:
//   Requests come in on req_valid/req_ready/req (kind 0 puts char_in at the
//   cursor, kind 1 reads the cell at read_row/read_col). Each request gives
//   one result on res_valid/res_ready/res: the read cell (zero for a put),
//   the cursor after the request and a scroll flag.
//   Colors and the active geometry sit on the APB port (4-byte registers:
//   text color, cursor color, columns, rows); write them only while idle.
//   A put that scrolls takes longer than one without, since the scroll
//   moves the rows up one cell per cycle through the single write port.
//   One request is in flight at a time; req_ready comes back the cycle
//   after the result is loaded into the output register.
//   After reset the store is swept to blank cells, one cell per cycle, so
//   req_ready stays low until the sweep is done; the cursor starts at 0,0.
//   If the receiver stalls, the result is held in the output register
//   and the next request waits at its last step.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25,
    parameter int TAB_STOP = 8
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam int STORE_CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
    localparam int CW = $clog2(STORE_CELLS + 1);
    localparam int TAB_N = 1 << COL_W;

    typedef logic [TAB_N-1:0][COLX_W-1:0] tab_tbl_t;

    function automatic tab_tbl_t tab_fill();
        tab_tbl_t t;
        for (int i = 0; i < TAB_N; i++)
        begin
            t[i] = COLX_W'(((i / TAB_STOP) + 1) * TAB_STOP);
        end
        return t;
    endfunction

    localparam tab_tbl_t TAB_NEXT = tab_fill();

    // configuration
    logic [7:0]       ink_attr_reg;
    logic [7:0]       cursor_attr_reg;
    logic [COL_W-1:0] cols_cfg_reg;
    logic [ROW_W-1:0] rows_cfg_reg;
    logic             cfg_we;

    // sequencer and datapath
    logic [3:0]       pc_reg, pc_next;
    uword_t           uw;
    logic             cond_true;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    cnt_m1;
    logic [CW-1:0]    src_idx;
    logic [CW-1:0]    lim_copy_reg, lim_copy_next;
    logic [CW-1:0]    lim_fill_reg, lim_fill_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             hit_reg, hit_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [7:0]       cuc_reg, cuc_next;
    req_t             req_q_reg, req_q_next;
    logic [7:0]       rchar_reg, rchar_next;
    logic [7:0]       rcolor_reg, rcolor_next;
    logic             scrolled_reg, scrolled_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    logic             out_free;

    logic [COL_W-1:0] cols_act;
    logic [ROW_W-1:0] rows_act;
    logic             geom_zero;
    logic             cur_in;
    logic             rd_in;

    logic [ROW_W-1:0] mul_a;
    logic [COL_W-1:0] mul_b;
    logic [MAC_W-1:0] mac;

    logic [COLX_W-1:0] col_a, col_b;
    logic [ROWX_W-1:0] row_a, row_b;
    logic              wrap;
    logic              scroll_now;
    logic              printable;
    logic [ROW_W-1:0]  row_c;

    logic [15:0]   screen_mem [STORE_CELLS];
    logic [15:0]   rdata_q;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [15:0]   mem_wd;

    // APB
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_TEXT_COLOR:   prdata = 32'(ink_attr_reg);
            REG_CURSOR_COLOR: prdata = 32'(cursor_attr_reg);
            REG_COLUMNS:      prdata = 32'(cols_cfg_reg);
            REG_ROWS:         prdata = 32'(rows_cfg_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ink_attr_reg    <= TEXT_COLOR_RST;
            cursor_attr_reg <= CURSOR_COLOR_RST;
            cols_cfg_reg    <= COLS_RST;
            rows_cfg_reg    <= ROWS_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_TEXT_COLOR:   ink_attr_reg    <= pwdata[7:0];
                REG_CURSOR_COLOR: cursor_attr_reg <= pwdata[7:0];
                REG_COLUMNS:      cols_cfg_reg    <= pwdata[COL_W-1:0];
                REG_ROWS:         rows_cfg_reg    <= pwdata[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // active geometry, saturated at the store size
    assign cols_act  = (int'(cols_cfg_reg) > MAX_COLS) ? COL_W'(MAX_COLS) : cols_cfg_reg;
    assign rows_act  = (int'(rows_cfg_reg) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : rows_cfg_reg;
    assign geom_zero = (cols_act == '0) || (rows_act == '0);
    assign cur_in    = (cur_row_reg < rows_act) && (cur_col_reg < cols_act);
    assign rd_in     = (req_q_reg.read_row < rows_act) && (req_q_reg.read_col < cols_act);

    // shared row*cols + col unit
    always_comb
    begin
        mul_a = cur_row_reg;
        mul_b = cur_col_reg;
        case (uw.op)
            OP_ADDR_RD:
            begin
                mul_a = req_q_reg.read_row;
                mul_b = req_q_reg.read_col;
            end
            OP_SCR_INIT:
            begin
                mul_a = rows_act - 1'b1;
                mul_b = '0;
            end
            default: ;
        endcase
    end

    assign mac = MAC_W'(mul_a) * MAC_W'(cols_act) + MAC_W'(mul_b);

    // cursor motion for a put
    assign printable = (req_q_reg.char_in != CHAR_TAB) && (req_q_reg.char_in != CHAR_LF)
                    && (req_q_reg.char_in != CHAR_CR);

    always_comb
    begin
        col_a = COLX_W'(cur_col_reg);
        row_a = ROWX_W'(cur_row_reg);
        case (req_q_reg.char_in)
            CHAR_TAB: col_a = TAB_NEXT[cur_col_reg];
            CHAR_LF:  row_a = ROWX_W'(cur_row_reg) + 1'b1;
            CHAR_CR:  col_a = '0;
            default:  col_a = COLX_W'(cur_col_reg) + 1'b1;
        endcase
    end

    assign wrap       = col_a >= COLX_W'(cols_act);
    assign col_b      = wrap ? '0 : col_a;
    assign row_b      = wrap ? row_a + 1'b1 : row_a;
    assign scroll_now = row_b >= ROWX_W'(rows_act);
    assign row_c      = scroll_now ? rows_act - 1'b1 : row_b[ROW_W-1:0];

    // sequencer
    assign uw        = ucode(pc_reg);
    assign out_free  = !res_valid_reg || res_ready;
    assign req_ready = (pc_reg == S_IDLE);

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:    cond_true = 1'b1;
            C_REQ:       cond_true = req_valid;
            C_READ:      cond_true = (req_q_reg.kind == KIND_READ);
            C_ZERO:      cond_true = geom_zero;
            C_NO_SCROLL: cond_true = !scroll_now;
            C_COPY_END:  cond_true = (cnt_reg == lim_copy_reg);
            C_FILL_END:  cond_true = (cnt_reg == lim_fill_reg);
            C_OUT_FREE:  cond_true = out_free;
            C_CLR_END:   cond_true = (cnt_reg == CW'(STORE_CELLS - 1));
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        case (uw.seq)
            SEQ_NEXT: pc_next = pc_reg + 1'b1;
            SEQ_JUMP: pc_next = cond_true ? uw.target : pc_reg + 1'b1;
            SEQ_WAIT: pc_next = cond_true ? uw.target : pc_reg;
            default:  pc_next = S_IDLE;
        endcase
    end

    // datapath
    assign cnt_m1  = cnt_reg - 1'b1;
    assign src_idx = cnt_reg + CW'(cols_act);

    always_comb
    begin
        cnt_next      = cnt_reg;
        lim_copy_next = lim_copy_reg;
        lim_fill_next = lim_fill_reg;
        addr_next     = addr_reg;
        hit_next      = hit_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        cuc_next      = cuc_reg;
        rchar_next    = rchar_reg;
        rcolor_next   = rcolor_reg;
        scrolled_next = scrolled_reg;
        req_q_next    = (req_valid && req_ready) ? req : req_q_reg;
        case (uw.op)
            OP_CLR_RES:
            begin
                rchar_next    = '0;
                rcolor_next   = '0;
                scrolled_next = 1'b0;
            end
            OP_ADDR_CUR:
            begin
                addr_next = AW'(mac);
                hit_next  = cur_in;
            end
            OP_ADDR_RD:
            begin
                addr_next = AW'(mac);
                hit_next  = rd_in;
            end
            OP_PUT:
            begin
                cur_row_next  = row_c;
                cur_col_next  = col_b[COL_W-1:0];
                scrolled_next = scroll_now;
            end
            OP_SCR_INIT:
            begin
                cnt_next      = '0;
                lim_copy_next = CW'(mac);
                lim_fill_next = CW'(mac + MAC_W'(cols_act));
            end
            OP_COPY:  cnt_next = cnt_reg + 1'b1;
            OP_FILL:  cnt_next = cnt_reg + 1'b1;
            OP_CLEAR: cnt_next = cnt_reg + 1'b1;
            OP_SHOW:  cuc_next = rdata_q[15:8];
            OP_CAP:
            begin
                if (hit_reg)
                begin
                    rchar_next  = rdata_q[7:0];
                    rcolor_next = rdata_q[15:8];
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (uw.op == OP_EMIT && out_free)
        begin
            res_valid_next          = 1'b1;
            res_next.cell_char      = rchar_reg;
            res_next.cell_color     = rcolor_reg;
            res_next.cursor_row_out = cur_row_reg;
            res_next.cursor_col_out = cur_col_reg;
            res_next.scrolled       = scrolled_reg;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_CLR;
            cnt_reg       <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cuc_reg       <= TEXT_COLOR_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cuc_reg       <= cuc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_copy_reg <= lim_copy_next;
        lim_fill_reg <= lim_fill_next;
        addr_reg     <= addr_next;
        hit_reg      <= hit_next;
        req_q_reg    <= req_q_next;
        rchar_reg    <= rchar_next;
        rcolor_reg   <= rcolor_next;
        scrolled_reg <= scrolled_next;
        res_reg      <= res_next;
    end

    // screen store ports; copy reads one row ahead and writes one cell behind
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = rdata_q;
        case (uw.op)
            OP_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg[AW-1:0];
                mem_wd = (cnt_reg == '0) ? {CURSOR_COLOR_RST, CHAR_SPACE}
                                         : {TEXT_COLOR_RST, CHAR_SPACE};
            end
            OP_PUT:
            begin
                // a printed byte replaces the whole cell, else restore the color
                mem_we = hit_reg;
                mem_wd = printable ? {ink_attr_reg, req_q_reg.char_in}
                                   : {cuc_reg, rdata_q[7:0]};
            end
            OP_COPY:
            begin
                mem_we = (cnt_reg != '0);
                mem_wa = cnt_m1[AW-1:0];
            end
            OP_FILL:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_m1[AW-1:0];
                mem_wd = {ink_attr_reg, CHAR_SPACE};
            end
            OP_SHOW:
            begin
                mem_we = 1'b1;
                mem_wd = {cursor_attr_reg, rdata_q[7:0]};
            end
            default: ;
        endcase
    end

    assign mem_ra = (uw.op == OP_COPY) ? src_idx[AW-1:0] : addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_wa] <= mem_wd;
        end
        rdata_q <= screen_mem[mem_ra];
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a previous one is in flight");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.scrolled |-> res.cursor_row_out == rows_act - 1'b1)
        else $error("scrolled result with cursor off the last row");

    a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_SHOW_WR |-> cur_row_reg < rows_act && cur_col_reg < cols_act)
        else $error("cursor shown outside the active area");

    a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_COPY |-> cnt_reg <= lim_copy_reg)
        else $error("scroll copy ran past its limit");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == S_FILL |-> cnt_reg > lim_copy_reg && cnt_reg <= lim_fill_reg)
        else $error("bottom row fill out of range");

endmodule
